FILE: design/cbd_pkg.sv
package cbd_pkg;

    // default size of the internal work memory
    localparam int RAM_DEPTH_DEF = 2048;

    // bus transaction kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    // where a transaction was routed
    typedef enum logic [2:0] {
        TGT_NONE      = 3'd0,
        TGT_CART      = 3'd1,
        TGT_RAM       = 3'd2,
        TGT_PPU       = 3'd3,
        TGT_APU       = 3'd4,
        TGT_PAD       = 3'd5,
        TGT_DMA_START = 3'd6,
        TGT_DMA_SRC   = 3'd7
    } t_target;

    // address map
    localparam logic [15:0] ADDR_RAM_END    = 16'h1FFF;
    localparam logic [15:0] ADDR_PPU_END    = 16'h3FFF;
    localparam logic [15:0] PPU_REG_MASK    = 16'h0007;
    localparam logic [15:0] ADDR_APU_FIRST  = 16'h4000;
    localparam logic [15:0] ADDR_APU_LAST   = 16'h4013;
    localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_PAD0       = 16'h4016;
    localparam logic [15:0] ADDR_APU_FRAME  = 16'h4017;
    localparam logic [7:0]  DMA_RAM_PAGE_LAST = ADDR_RAM_END[15:8];

    // master tick phases, cpu slots at phases 0 and 3
    localparam logic [2:0] PHASE_CPU_A = 3'd0;
    localparam logic [2:0] PHASE_CPU_B = 3'd3;
    localparam logic [2:0] PHASE_LAST  = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        peek_req;
        logic        cart_claims;
        logic [7:0]  ext_data;
        logic [7:0]  pad_buttons;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        t_target     target;
        logic [15:0] target_addr;
        logic        peek_out;
        logic        cpu_step;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_data;
        logic        dma_active;
    } t_out_item;

    typedef struct packed {
        logic [7:0] pad_shift;
        logic [2:0] tick_phase;
        logic       dma_busy;
        logic       dma_wait_sync;
        logic [7:0] src_page;
        logic [7:0] dma_offset;
        logic [7:0] dma_byte;
    } t_bus_state;

    localparam t_bus_state BUS_STATE_RESET = '{
        pad_shift:     8'd0,
        tick_phase:    3'd0,
        dma_busy:      1'b0,
        dma_wait_sync: 1'b1,
        src_page:      8'd0,
        dma_offset:    8'd0,
        dma_byte:      8'd0
    };

endpackage

FILE: design/cbd_if.sv
interface cbd_in_if;
    import cbd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface

interface cbd_out_if;
    import cbd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source(output valid, output item, input ready);
    modport sink(input valid, input item, output ready);
endinterface

FILE: design/cbd_work_ram.sv
module cbd_work_ram #(
    parameter int DEPTH = cbd_pkg::RAM_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_idx,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_idx,
    output logic [7:0]    o_rd_data,
    output logic          o_clearing
);
    import cbd_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic          r_clr_active;
    logic [AW-1:0] r_clr_idx;
    logic [7:0]    r_rd_data;
    logic          r_byp;
    logic [7:0]    r_byp_data;
    logic          wr_en;
    logic [AW-1:0] wr_idx;
    logic [7:0]    wr_data;

    // clearing sweep after reset owns the write port
    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_idx  = r_clr_idx;
            wr_data = 8'd0;
        end else begin
            wr_en   = i_wr_en;
            wr_idx  = i_wr_idx;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // read with write-through for a write at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_idx];
            r_byp      <= wr_en && (wr_idx == i_rd_idx);
            r_byp_data <= wr_data;
        end
    end

    assign o_rd_data  = r_byp ? r_byp_data : r_rd_data;
    assign o_clearing = r_clr_active;

endmodule

FILE: design/cbd_decode.sv
module cbd_decode #(
    parameter int AW = $clog2(cbd_pkg::RAM_DEPTH_DEF)
) (
    input  cbd_pkg::t_in_item   i_item,
    input  cbd_pkg::t_bus_state i_state,
    input  logic [7:0]          i_ram_data,
    output cbd_pkg::t_bus_state o_next,
    output cbd_pkg::t_out_item  o_result,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_idx,
    output logic [7:0]          o_wr_data
);
    import cbd_pkg::*;

    logic        is_apu;
    logic        cpu_slot;
    logic [15:0] dma_src;
    logic [7:0]  next_offset;

    assign is_apu = ((i_item.addr >= ADDR_APU_FIRST) && (i_item.addr <= ADDR_APU_LAST))
                    || (i_item.addr == ADDR_APU_STATUS) || (i_item.addr == ADDR_APU_FRAME);
    assign cpu_slot    = (i_state.tick_phase == PHASE_CPU_A)
                         || (i_state.tick_phase == PHASE_CPU_B);
    assign dma_src     = {i_state.src_page, i_state.dma_offset};
    assign next_offset = i_state.dma_offset + 8'd1;

    always_comb begin
        o_next    = i_state;
        o_result  = '0;
        o_wr_en   = 1'b0;
        o_wr_idx  = i_item.addr[AW-1:0];
        o_wr_data = i_item.data;
        unique case (i_item.kind)
            KIND_READ: begin
                if (i_item.cart_claims) begin
                    o_result.target    = TGT_CART;
                    o_result.read_data = i_item.ext_data;
                end else if (i_item.addr <= ADDR_RAM_END) begin
                    o_result.target      = TGT_RAM;
                    o_result.target_addr = 16'(i_item.addr[AW-1:0]);
                    o_result.read_data   = i_ram_data;
                end else if (i_item.addr <= ADDR_PPU_END) begin
                    o_result.target      = TGT_PPU;
                    o_result.target_addr = i_item.addr & PPU_REG_MASK;
                    o_result.read_data   = i_item.ext_data;
                    o_result.peek_out    = i_item.peek_req;
                end else if (is_apu) begin
                    o_result.target      = TGT_APU;
                    o_result.target_addr = i_item.addr;
                    o_result.read_data   = i_item.ext_data;
                end else if (i_item.addr == ADDR_PAD0) begin
                    o_result.target      = TGT_PAD;
                    o_result.target_addr = i_item.addr;
                    o_result.read_data   = {7'd0, i_state.pad_shift[0]};
                    o_next.pad_shift     = {1'b0, i_state.pad_shift[7:1]};
                end
            end
            KIND_WRITE: begin
                if (i_item.cart_claims) begin
                    o_result.target = TGT_CART;
                end else if (i_item.addr <= ADDR_RAM_END) begin
                    o_result.target      = TGT_RAM;
                    o_result.target_addr = 16'(i_item.addr[AW-1:0]);
                    o_wr_en              = 1'b1;
                end else if (i_item.addr <= ADDR_PPU_END) begin
                    o_result.target      = TGT_PPU;
                    o_result.target_addr = i_item.addr & PPU_REG_MASK;
                end else if (is_apu) begin
                    o_result.target      = TGT_APU;
                    o_result.target_addr = i_item.addr;
                end else if (i_item.addr == ADDR_OAM_DMA) begin
                    o_result.target      = TGT_DMA_START;
                    o_result.target_addr = {i_item.data, 8'd0};
                    o_next.src_page      = i_item.data;
                    o_next.dma_offset    = 8'd0;
                    o_next.dma_busy      = 1'b1;
                end else if (i_item.addr == ADDR_PAD0) begin
                    o_result.target      = TGT_PAD;
                    o_result.target_addr = i_item.addr;
                    o_next.pad_shift     = i_item.pad_buttons;
                end
            end
            KIND_TICK: begin
                if (cpu_slot) begin
                    if (!i_state.dma_busy) begin
                        o_result.cpu_step = 1'b1;
                    end else if (i_state.dma_wait_sync) begin
                        if (i_state.tick_phase == PHASE_CPU_B) begin
                            o_next.dma_wait_sync = 1'b0;
                        end
                    end else if (i_state.tick_phase == PHASE_CPU_A) begin
                        // source fetch slot
                        if (!i_item.cart_claims && (i_state.src_page <= DMA_RAM_PAGE_LAST)) begin
                            o_next.dma_byte = i_ram_data;
                        end else begin
                            o_next.dma_byte = i_item.ext_data;
                        end
                        o_result.target      = TGT_DMA_SRC;
                        o_result.target_addr = dma_src;
                        o_result.read_data   = o_next.dma_byte;
                    end else begin
                        // sprite memory write slot
                        o_result.oam_write = 1'b1;
                        o_result.oam_index = i_state.dma_offset;
                        o_result.oam_data  = i_state.dma_byte;
                        o_next.dma_offset  = next_offset;
                        if (next_offset == 8'd0) begin
                            o_next.dma_busy      = 1'b0;
                            o_next.dma_wait_sync = 1'b1;
                        end
                    end
                end
                o_next.tick_phase = (i_state.tick_phase == PHASE_LAST) ? 3'd0
                                    : i_state.tick_phase + 3'd1;
            end
            default: begin
            end
        endcase
        o_result.dma_active = o_next.dma_busy;
    end

endmodule

FILE: design/console_bus_decode_with_oam_dma.sv
// CPU bus decoder of the console with sprite DMA. Each input transaction is a CPU read, a CPU
// write or one master clock tick; each gives exactly one result transaction carrying the
// routing decision, returned byte, CPU step enable and sprite memory write. The block takes
// one transaction per cycle while the result is not stalled: the decode, the bus state update
// and the work RAM write all sit between the input register and the result register, and the
// work RAM read for the next transaction is issued as it is accepted, so that the decode sees
// registered read data once the transaction sits in the input register. The result register
// loads when a transaction leaves the input register, which holds it while the result
// register is stalled. After reset the work RAM is swept to zero over all RAM_DEPTH locations
// (2048 at the default), during which no input transaction is accepted. RAM_DEPTH must be a
// power of two; the work RAM is indexed by the low address bits and mirrored over 0x0000-0x1FFF.
module console_bus_decode_with_oam_dma #(
    parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbd_in_if.sink    i_in,
    cbd_out_if.source o_out
);
    import cbd_pkg::*;

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    // decode stage register
    logic       r_s1_valid;
    t_in_item   r_s1_item;
    // bus state: pad shifter, tick phase, dma sequencer
    t_bus_state r_state;
    t_bus_state n_state;
    // result register
    logic       r_out_valid;
    t_out_item  r_out_item;

    t_bus_state    dec_next;
    t_out_item     dec_result;
    logic          dec_wr_en;
    logic [RAM_AW-1:0] dec_wr_idx;
    logic [7:0]    dec_wr_data;
    logic [7:0]    ram_data;
    logic          ram_clearing;
    logic          s1_fire;
    logic          accept;
    logic [15:0]   rd_addr;

    // decode stage moves on when the result register is free or drains now
    assign s1_fire  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !ram_clearing && (!r_s1_valid || s1_fire);
    assign accept   = i_in.valid && i_in.ready;

    // bus state as the accepted transaction will see it
    assign n_state = s1_fire ? dec_next : r_state;

    // ticks fetch the dma source byte, cpu accesses their own address
    assign rd_addr = (i_in.item.kind == KIND_TICK) ? {n_state.src_page, n_state.dma_offset}
                     : i_in.item.addr;

    cbd_work_ram #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (s1_fire && dec_wr_en),
        .i_wr_idx   (dec_wr_idx),
        .i_wr_data  (dec_wr_data),
        .i_rd_en    (accept),
        .i_rd_idx   (rd_addr[RAM_AW-1:0]),
        .o_rd_data  (ram_data),
        .o_clearing (ram_clearing)
    );

    cbd_decode #(
        .AW (RAM_AW)
    ) u_decode (
        .i_item     (r_s1_item),
        .i_state    (r_state),
        .i_ram_data (ram_data),
        .o_next     (dec_next),
        .o_result   (dec_result),
        .o_wr_en    (dec_wr_en),
        .o_wr_idx   (dec_wr_idx),
        .o_wr_data  (dec_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= BUS_STATE_RESET;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in.item;
        end
        if (s1_fire) begin
            r_out_item <= dec_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

endmodule

FILE: design/cbd_checker.sv
module cbd_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cbd_pkg::t_out_item  i_out_item
);
    import cbd_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    // the cpu is never clocked while a transfer is still running
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.cpu_step |-> !i_out_item.dma_active)
        else $error("cpu step during sprite dma");

    // a source fetch only happens inside a transfer
    a_src_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.target == TGT_DMA_SRC) |-> i_out_item.dma_active)
        else $error("dma source read outside a transfer");

    // a dma start leaves the transfer running
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_item.target == TGT_DMA_START) |-> i_out_item.dma_active)
        else $error("dma start without active transfer");

endmodule

bind console_bus_decode_with_oam_dma cbd_checker u_cbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);
